### src/hhr_pkg.sv
// hhr_pkg: shared constants and small helpers for the hsv/hsl to rgb converter
// hue scale factor, sector codes, per-channel sector offsets, modulo-6 reduction
// no dependencies
package hhr_pkg;

	localparam int FRAC_BITS_DEF = 12;
	localparam int HUE_BITS_DEF  = 16;

	// round(3/pi * 2^16), applied as multiply then arithmetic shift
	localparam int SCALE_SHIFT = 16;
	localparam logic [16:0] THREE_OVER_PI_Q16 = 17'd62582;

	// hue sectors of the trapezoid
	localparam logic [2:0] SEC_RISE  = 3'd0;
	localparam logic [2:0] SEC_TOP_A = 3'd1;
	localparam logic [2:0] SEC_TOP_B = 3'd2;
	localparam logic [2:0] SEC_FALL  = 3'd3;
	localparam logic [2:0] SEC_BOT_A = 3'd4;
	localparam logic [2:0] SEC_BOT_B = 3'd5;
	localparam logic [3:0] SEC_COUNT = 4'd6;

	// sector offset per channel
	localparam logic [2:0] RED_SHIFT   = 3'd2;
	localparam logic [2:0] GREEN_SHIFT = 3'd0;
	localparam logic [2:0] BLUE_SHIFT  = 3'd4;

	localparam int MOD_W = 32;

	// residue mod 6 from parity and a base-4 digit sum for mod 3
	function automatic logic [2:0] mod6(input logic [MOD_W-1:0] u);
		logic [7:0] acc;
		logic [3:0] f1;
		logic [2:0] f2;
		logic [2:0] f3;
		logic [1:0] m3;
		acc = '0;
		for (int i = 0; i < MOD_W / 2; i++) begin
			acc = acc + 8'(u[2*i +: 2]);
		end
		f1 = 4'(acc[1:0]) + 4'(acc[3:2]) + 4'(acc[5:4]) + 4'(acc[7:6]);
		f2 = 3'(f1[1:0]) + 3'(f1[3:2]);
		f3 = 3'(f2[1:0]) + 3'(f2[2]);
		m3 = (f3 >= 3'd3) ? 2'(f3 - 3'd3) : f3[1:0];
		mod6 = (m3[0] != u[0]) ? (3'(m3) + 3'd3) : 3'(m3);
	endfunction

	// sector plus channel offset, wrapped into 0..5
	function automatic logic [2:0] sect_add(input logic [2:0] k, input logic [2:0] sh);
		logic [3:0] sum;
		sum = 4'(k) + 4'(sh);
		sect_add = (sum >= SEC_COUNT) ? 3'(sum - SEC_COUNT) : sum[2:0];
	endfunction

endpackage

### src/hsv_hsl_to_rgb_top.sv
// hsv_hsl_to_rgb_top: hsv or hsl pixel to rgb, fully pipelined
// uses hhr_pkg for constants and helpers, hhr_div for the hsl saturation quotient
//
//   channel | signals                                   | dir | handshake
//   in      | hue_angle, saturation, brightness         | in  | in_valid / in_stall
//   out     | red_level, green_level, blue_level        | out | out_valid / out_stall
//   cfg     | cfg_wdata (color_model)                   | in  | cfg_we
//
// one beat per clock sustained while out_stall stays low
// the saturation divider in the middle of the pipeline resolves one quotient bit per stage
// arst_n clears all valid bits and color_model; no clearing pass is needed
// each stage holds while the next one is full and stalled, bubbles are squeezed out,
// so a beat can be taken while a finished result waits at the output register
module hsv_hsl_to_rgb_top
	import hhr_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int HUE_BITS  = HUE_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic                       cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [HUE_BITS-1:0] hue_angle,
	input  logic [FRAC_BITS:0]         saturation,
	input  logic [FRAC_BITS:0]         brightness,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [FRAC_BITS:0]         red_level,
	output logic [FRAC_BITS:0]         green_level,
	output logic [FRAC_BITS:0]         blue_level
);

	localparam int ONE_W  = FRAC_BITS + 1;
	localparam logic [ONE_W-1:0] ONE = ONE_W'(1) << FRAC_BITS;
	localparam int DEV_W  = ONE_W + 2;
	localparam int PROD_W = HUE_BITS + 18;
	localparam int Q_W    = PROD_W - SCALE_SHIFT;
	localparam int QE_W   = (Q_W > FRAC_BITS) ? Q_W : FRAC_BITS + 1;
	localparam int QH_W   = QE_W - FRAC_BITS;
	localparam int U_W    = QH_W + 2;
	localparam int CW_W   = 2 * FRAC_BITS + 1;
	localparam int VAL_W  = FRAC_BITS + 2;
	localparam int DVD_W  = VAL_W + ONE_W;
	localparam int MIX_W  = 2 * FRAC_BITS + 1;
	localparam int LP_W   = ONE_W + MIX_W;
	localparam int LVL_W  = LP_W - 2 * FRAC_BITS;
	localparam int SB_W   = 2 + 3 + FRAC_BITS + 2 * ONE_W;

	function automatic logic [ONE_W-1:0] trap(input logic [2:0] k,
			input logic [FRAC_BITS-1:0] f);
		case (k) inside
			SEC_RISE:             trap = ONE_W'(f);
			SEC_TOP_A, SEC_TOP_B: trap = ONE;
			SEC_FALL:             trap = ONE - ONE_W'(f);
			SEC_BOT_A, SEC_BOT_B: trap = '0;
			default:              trap = '0;
		endcase
	endfunction

	// configuration
	logic color_model_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_model_q <= 1'b0;
		end else if (cfg_we) begin
			color_model_q <= cfg_wdata;
		end
	end

	// stage enables, back to front
	logic en_s1, en_s2, en_s3, en_s4, en_s5, en_s6, en_s7, en_s8;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic div_in_stall, div_out_valid;

	assign en_s8    = ~vld_s8 | ~out_stall;
	assign en_s7    = ~vld_s7 | en_s8;
	assign en_s6    = ~vld_s6 | en_s7;
	assign en_s5    = ~vld_s5 | en_s6;
	assign en_s4    = ~vld_s4 | ~div_in_stall;
	assign en_s3    = ~vld_s3 | en_s4;
	assign en_s2    = ~vld_s2 | en_s3;
	assign en_s1    = ~vld_s1 | en_s2;
	assign in_stall = ~en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= in_valid;
			if (en_s2) vld_s2 <= vld_s1;
			if (en_s3) vld_s3 <= vld_s2;
			if (en_s4) vld_s4 <= vld_s3;
			if (en_s5) vld_s5 <= div_out_valid;
			if (en_s6) vld_s6 <= vld_s5;
			if (en_s7) vld_s7 <= vld_s6;
			if (en_s8) vld_s8 <= vld_s7;
		end
	end

	// s1: clamp, hue scaling product, hsl distance from mid gray
	logic [ONE_W-1:0]         sat_c, bri_c, d_c;
	logic [DEV_W-1:0]         dev, dev_abs;
	logic signed [PROD_W-1:0] hue_prod;

	assign sat_c    = (saturation > ONE) ? ONE : saturation;
	assign bri_c    = (brightness > ONE) ? ONE : brightness;
	assign dev      = {1'b0, bri_c, 1'b0} - DEV_W'(ONE);
	assign dev_abs  = dev[DEV_W-1] ? (DEV_W'(0) - dev) : dev;
	assign d_c      = ONE - dev_abs[ONE_W-1:0];
	assign hue_prod = hue_angle * $signed({1'b0, THREE_OVER_PI_Q16});

	logic signed [PROD_W-1:0] hue_prod_s1;
	logic [ONE_W-1:0]         sat_s1, bri_s1, d_s1;

	always_ff @(posedge clk) begin
		if (en_s1) begin
			hue_prod_s1 <= hue_prod;
			sat_s1      <= sat_c;
			bri_s1      <= bri_c;
			d_s1        <= d_c;
		end
	end

	// s2: sector and fraction, chroma product
	logic signed [Q_W-1:0]  q;
	logic signed [QE_W-1:0] q_ext;
	logic [QH_W-1:0]        qh;
	logic [U_W-1:0]         qh_pos;
	logic [2*ONE_W-1:0]     cw_full;

	assign q       = hue_prod_s1[PROD_W-1:SCALE_SHIFT];
	assign q_ext   = QE_W'(q);
	assign qh      = q_ext[QE_W-1:FRAC_BITS];
	assign qh_pos  = {{2{qh[QH_W-1]}}, qh} + (U_W'(3) << QH_W);
	assign cw_full = d_s1 * sat_s1;

	logic [2:0]           sector_s2;
	logic [FRAC_BITS-1:0] frac_s2;
	logic [CW_W-1:0]      cw_s2;
	logic [ONE_W-1:0]     sat_s2, bri_s2;

	always_ff @(posedge clk) begin
		if (en_s2) begin
			sector_s2 <= mod6(MOD_W'(qh_pos));
			frac_s2   <= q_ext[FRAC_BITS-1:0];
			cw_s2     <= cw_full[CW_W-1:0];
			sat_s2    <= sat_s1;
			bri_s2    <= bri_s1;
		end
	end

	// s3: chroma and hsl value
	logic [CW_W-1:0] cw_rnd, cw_one;

	assign cw_rnd = cw_s2 + CW_W'(ONE >> 1);
	assign cw_one = cw_s2 + CW_W'(ONE);

	logic [2:0]           sector_s3;
	logic [FRAC_BITS-1:0] frac_s3;
	logic [ONE_W-1:0]     c_s3, sat_s3, bri_s3;
	logic [VAL_W-1:0]     val_s3;

	always_ff @(posedge clk) begin
		if (en_s3) begin
			sector_s3 <= sector_s2;
			frac_s3   <= frac_s2;
			c_s3      <= cw_rnd[CW_W-1:FRAC_BITS];
			val_s3    <= VAL_W'(bri_s2) + VAL_W'(cw_one[CW_W-1:FRAC_BITS+1]);
			sat_s3    <= sat_s2;
			bri_s3    <= bri_s2;
		end
	end

	// s4: dividend, quotient use flag, effective value
	logic [ONE_W-1:0] val_clip;

	assign val_clip = (val_s3 > VAL_W'(ONE)) ? ONE : val_s3[ONE_W-1:0];

	logic [DVD_W-1:0]     dvd_s4;
	logic [VAL_W-1:0]     val_s4;
	logic                 hsl_s4, useq_s4;
	logic [2:0]           sector_s4;
	logic [FRAC_BITS-1:0] frac_s4;
	logic [ONE_W-1:0]     sat_s4, v_s4;

	always_ff @(posedge clk) begin
		if (en_s4) begin
			dvd_s4    <= DVD_W'({c_s3, {FRAC_BITS{1'b0}}}) + DVD_W'(val_s3[VAL_W-1:1]);
			val_s4    <= val_s3;
			hsl_s4    <= color_model_q;
			useq_s4   <= (val_s3 != '0) && (VAL_W'(c_s3) <= val_s3);
			sector_s4 <= sector_s3;
			frac_s4   <= frac_s3;
			sat_s4    <= sat_s3;
			v_s4      <= color_model_q ? val_clip : bri_s3;
		end
	end

	// hsl saturation quotient
	logic [ONE_W-1:0]     div_quo;
	logic [SB_W-1:0]      div_side;
	logic                 dq_hsl, dq_useq;
	logic [2:0]           dq_sector;
	logic [FRAC_BITS-1:0] dq_frac;
	logic [ONE_W-1:0]     dq_sat, dq_v;

	hhr_div #(
		.DIV_W (VAL_W),
		.QUO_W (ONE_W),
		.SB_W  (SB_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_s4),
		.in_stall  (div_in_stall),
		.dividend  (dvd_s4),
		.divisor   (val_s4),
		.in_side   ({hsl_s4, useq_s4, sector_s4, frac_s4, sat_s4, v_s4}),
		.out_valid (div_out_valid),
		.out_stall (~en_s5),
		.quotient  (div_quo),
		.out_side  (div_side)
	);

	assign {dq_hsl, dq_useq, dq_sector, dq_frac, dq_sat, dq_v} = div_side;

	// s5: effective saturation, trapezoid per channel, s*t
	logic [ONE_W-1:0] s_eff;
	logic [2:0]       ch_sector [3];
	logic [2:0]       ch_shift  [3];

	assign s_eff       = dq_hsl ? (dq_useq ? div_quo : '0) : dq_sat;
	assign ch_shift[0] = RED_SHIFT;
	assign ch_shift[1] = GREEN_SHIFT;
	assign ch_shift[2] = BLUE_SHIFT;

	logic [MIX_W-1:0] st_s5 [3];
	logic [ONE_W-1:0] oms_s5, v_s5;
	logic [MIX_W-1:0] mix_s6 [3];
	logic [ONE_W-1:0] v_s6;
	logic [LP_W-1:0]  lp_s7 [3];
	logic [ONE_W-1:0] lvl_s8 [3];

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [2*ONE_W-1:0] st_full;
		logic [LP_W-1:0]    lp_full;
		logic [LVL_W-1:0]   lvl;

		assign ch_sector[c] = sect_add(dq_sector, ch_shift[c]);
		assign st_full      = s_eff * trap(ch_sector[c], dq_frac);
		assign lp_full      = v_s6 * mix_s6[c];
		assign lvl          = lp_s7[c][LP_W-1:2*FRAC_BITS];

		always_ff @(posedge clk) begin
			if (en_s5) begin
				st_s5[c] <= st_full[MIX_W-1:0];
			end
			if (en_s6) begin
				mix_s6[c] <= {oms_s5, {FRAC_BITS{1'b0}}} + st_s5[c];
			end
			if (en_s7) begin
				lp_s7[c] <= lp_full + (LP_W'(1) << (2 * FRAC_BITS - 1));
			end
			if (en_s8) begin
				lvl_s8[c] <= (lvl > LVL_W'(ONE)) ? ONE : lvl[ONE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s5) begin
			oms_s5 <= ONE - s_eff;
			v_s5   <= dq_v;
		end
		if (en_s6) begin
			v_s6 <= v_s5;
		end
	end

	assign out_valid   = vld_s8;
	assign red_level   = lvl_s8[0];
	assign green_level = lvl_s8[1];
	assign blue_level  = lvl_s8[2];

`ifndef SYNTHESIS
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> vld_s1)
		else $error("accepted beat did not reach stage 1");

	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 && useq_s4 |-> dvd_s4[DVD_W-1:ONE_W] < val_s4)
		else $error("divider partial remainder not below divisor");

	a_quo_max: assert property (@(posedge clk) disable iff (!arst_n)
		div_out_valid && dq_hsl && dq_useq |-> div_quo <= ONE)
		else $error("hsl saturation quotient above one");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s8 && !out_stall && !vld_s7 |=> !vld_s8)
		else $error("output beat repeated after hand-off");
`endif

endmodule

### src/hhr_div.sv
// hhr_div: pipelined restoring divider, one quotient bit per stage
// carries a sideband word alongside each beat; valid/stall on both sides
// no package dependencies
module hhr_div #(
	parameter int DIV_W = 14,
	parameter int QUO_W = 13,
	parameter int SB_W  = 42
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [DIV_W+QUO_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	input  logic [SB_W-1:0]  in_side,
	output logic             out_valid,
	input  logic             out_stall,
	output logic [QUO_W-1:0] quotient,
	output logic [SB_W-1:0]  out_side
);

	logic             vld_s  [QUO_W];
	logic [DIV_W-1:0] rem_s  [QUO_W];
	logic [DIV_W-1:0] dvs_s  [QUO_W];
	logic [QUO_W-1:0] sh_s   [QUO_W];
	logic [SB_W-1:0]  side_s [QUO_W];
	logic [QUO_W:0]   en;

	assign en[QUO_W] = ~out_stall;

	for (genvar k = 0; k < QUO_W; k++) begin : g_step
		logic             vld_in;
		logic [DIV_W-1:0] rem_in;
		logic [DIV_W-1:0] dvs_in;
		logic [QUO_W-1:0] sh_in;
		logic [SB_W-1:0]  side_in;
		logic [DIV_W:0]   trial;
		logic [DIV_W:0]   diff;
		logic             ge;

		if (k == 0) begin : g_first
			assign vld_in  = in_valid;
			assign rem_in  = dividend[DIV_W+QUO_W-1:QUO_W];
			assign sh_in   = dividend[QUO_W-1:0];
			assign dvs_in  = divisor;
			assign side_in = in_side;
		end else begin : g_next
			assign vld_in  = vld_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign sh_in   = sh_s[k-1];
			assign dvs_in  = dvs_s[k-1];
			assign side_in = side_s[k-1];
		end

		assign trial = {rem_in, sh_in[QUO_W-1]};
		assign diff  = trial - {1'b0, dvs_in};
		assign ge    = (trial >= {1'b0, dvs_in});
		assign en[k] = ~vld_s[k] | en[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en[k]) begin
				vld_s[k] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				rem_s[k]  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
				sh_s[k]   <= {sh_in[QUO_W-2:0], ge};
				dvs_s[k]  <= dvs_in;
				side_s[k] <= side_in;
			end
		end
	end

	assign in_stall  = ~en[0];
	assign out_valid = vld_s[QUO_W-1];
	assign quotient  = sh_s[QUO_W-1];
	assign out_side  = side_s[QUO_W-1];

endmodule
